/* rtl/rdc_pkg.sv */
package rdc_pkg;

   // Field widths
   localparam int VALUE_BITS = 32;
   localparam int RADIX_W    = 6;
   localparam int CHAR_W     = 7;
   localparam int INDEX_W    = 5;

   // Divider step counter
   localparam int STEP_W = $clog2(VALUE_BITS);

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(31);

   localparam logic [CHAR_W-1:0] ASCII_ZERO   = CHAR_W'(8'h30);
   localparam logic [CHAR_W-1:0] ASCII_A_BIAS = CHAR_W'(8'h37); // 'A' - 10
   localparam logic [CHAR_W-1:0] ERROR_CHAR   = '0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // Digit value 0..35 to ASCII '0'..'9', 'A'..'Z'
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = CHAR_W'(d);
      if (d < RADIX_W'(10)) begin
         return ASCII_ZERO + d_ext;
      end else begin
         return ASCII_A_BIAS + d_ext;
      end
   endfunction

endpackage

/* rtl/rdc_req_if.sv */
interface rdc_req_if;
   logic                             valid;
   logic                             ready;
   logic [rdc_pkg::VALUE_BITS-1:0]   value;
   logic [rdc_pkg::RADIX_W-1:0]      radix;

   modport source (output valid, output value, output radix, input ready);
   modport sink   (input valid, input value, input radix, output ready);
endinterface

/* rtl/rdc_rsp_if.sv */
interface rdc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rdc_pkg::CHAR_W-1:0]    digit_char;
   logic [rdc_pkg::INDEX_W-1:0]   digit_index;
   logic                          last;
   logic                          bad_radix;

   modport source (output valid, output digit_char, output digit_index,
                   output last, output bad_radix, input ready);
   modport sink   (input valid, input digit_char, input digit_index,
                   input last, input bad_radix, output ready);
endinterface

/* rtl/radix_digit_converter.sv */
// Radix digit converter: takes an unsigned 32-bit value and a radix (2..36)
// on the req channel and returns its digits on the rsp channel as ASCII
// characters ('0'-'9', then 'A'-'Z'), least significant digit first, one
// item per digit, each tagged with its position; the most significant digit
// carries last. A zero value gives a single '0'. A radix outside 2..36 gives
// one item with bad_radix and last set and digit_char 0. The block handles
// one request at a time and drops req ready until its final digit has been
// taken. Each digit comes from a shared restoring divider that retires one
// quotient bit per cycle, then waits in the output stage until rsp takes it.
// The longest request is radix 2, 32 digits. A bad radix skips the divider
// and goes straight to the output stage.
module radix_digit_converter (
   input  logic          clock,
   input  logic          reset,
   rdc_req_if.sink       req_chan,
   rdc_rsp_if.source     rsp_chan
);

   rdc_pkg::state_type state_ff, state_in;

   // Divider working registers: quotient shifts left, partial remainder builds up
   logic [rdc_pkg::VALUE_BITS-1:0] quo_ff, quo_in;
   logic [rdc_pkg::RADIX_W-1:0]    rem_ff, rem_in;
   logic [rdc_pkg::RADIX_W-1:0]    radix_ff, radix_in;
   logic [rdc_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [rdc_pkg::INDEX_W-1:0]    pos_ff, pos_in;

   // Output holding register
   logic [rdc_pkg::CHAR_W-1:0]     char_ff, char_in;
   logic                           last_ff, last_in;
   logic                           bad_ff, bad_in;

   logic req_fire, rsp_fire, radix_bad, last_step;

   // Shared divider slice
   logic [rdc_pkg::RADIX_W:0]      trial;
   logic                           trial_ge;
   logic [rdc_pkg::RADIX_W-1:0]    trial_rem;
   logic [rdc_pkg::VALUE_BITS-1:0] quo_shift;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign radix_bad = (req_chan.radix < rdc_pkg::RADIX_MIN) ||
                      (req_chan.radix > rdc_pkg::RADIX_MAX);
   assign last_step = (step_ff == rdc_pkg::STEP_W'(rdc_pkg::VALUE_BITS - 1));

   // One restoring-division step: bring down the next quotient bit, try subtract
   always_comb begin
      trial     = {rem_ff, quo_ff[rdc_pkg::VALUE_BITS-1]};
      trial_ge  = (trial >= {1'b0, radix_ff});
      trial_rem = trial_ge ? rdc_pkg::RADIX_W'(trial - {1'b0, radix_ff})
                           : rdc_pkg::RADIX_W'(trial);
      quo_shift = {quo_ff[rdc_pkg::VALUE_BITS-2:0], trial_ge};
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rdc_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = radix_bad ? rdc_pkg::ST_EMIT : rdc_pkg::ST_DIVIDE;
            end
         end
         rdc_pkg::ST_DIVIDE: begin
            if (last_step) begin
               state_in = rdc_pkg::ST_EMIT;
            end
         end
         rdc_pkg::ST_EMIT: begin
            if (rsp_fire) begin
               state_in = last_ff ? rdc_pkg::ST_IDLE : rdc_pkg::ST_DIVIDE;
            end
         end
         default: state_in = rdc_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output register
   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      step_in  = step_ff;
      pos_in   = pos_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      bad_in   = bad_ff;
      unique case (state_ff)
         rdc_pkg::ST_IDLE: begin
            if (req_fire) begin
               quo_in   = req_chan.value;
               rem_in   = '0;
               radix_in = req_chan.radix;
               step_in  = '0;
               pos_in   = '0;
               // error item goes straight to the output stage
               char_in  = rdc_pkg::ERROR_CHAR;
               last_in  = 1'b1;
               bad_in   = radix_bad;
            end
         end
         rdc_pkg::ST_DIVIDE: begin
            quo_in  = quo_shift;
            rem_in  = trial_rem;
            step_in = step_ff + rdc_pkg::STEP_W'(1);
            if (last_step) begin
               char_in = rdc_pkg::digit_to_ascii(trial_rem);
               last_in = (quo_shift == '0) || (pos_ff == rdc_pkg::LAST_INDEX);
               bad_in  = 1'b0;
            end
         end
         rdc_pkg::ST_EMIT: begin
            if (rsp_fire && !last_ff) begin
               // quotient already in quo_ff; restart for the next digit
               rem_in  = '0;
               step_in = '0;
               pos_in  = pos_ff + rdc_pkg::INDEX_W'(1);
            end
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdc_pkg::ST_IDLE;
         step_ff  <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      bad_ff   <= bad_in;
   end

   assign req_chan.ready       = (state_ff == rdc_pkg::ST_IDLE);
   assign rsp_chan.valid       = (state_ff == rdc_pkg::ST_EMIT);
   assign rsp_chan.digit_char  = char_ff;
   assign rsp_chan.digit_index = pos_ff;
   assign rsp_chan.last        = last_ff;
   assign rsp_chan.bad_radix   = bad_ff;

   // Checks

   // never take a new request while a digit is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("req ready while rsp valid");

   // error item is a single, empty item
   a_bad_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.bad_radix) |->
         (rsp_chan.last && rsp_chan.digit_char == rdc_pkg::ERROR_CHAR &&
          rsp_chan.digit_index == '0))
      else $error("malformed bad_radix item");

   // partial remainder stays below the radix while dividing
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rdc_pkg::ST_DIVIDE) |-> (rem_ff < radix_ff))
      else $error("divider remainder out of range");

   // taking the final digit frees the block
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_chan.last) |=> req_chan.ready)
      else $error("block not idle after last digit");

endmodule

/* verif/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // ASCII codes for the two halves of the digit alphabet
   localparam logic [rdc_pkg::CHAR_W-1:0] CHAR_ZERO   = 7'h30;   // '0'
   localparam logic [rdc_pkg::CHAR_W-1:0] CHAR_LETTER = 7'h41;   // 'A'
   localparam int RANDOM_ITEMS = 287;
   localparam int TAIL_CYCLES  = 1100;   // a little over one worst-case item

   // One expected digit item on the result channel
   typedef struct packed {
      logic [rdc_pkg::CHAR_W-1:0]  ch;
      logic [rdc_pkg::INDEX_W-1:0] idx;
      logic                        last;
      logic                        bad;
   } digit_type;

   // Expands each accepted request into its digit items and checks the block's
   // output against them in order.
   class digit_scoreboard;
      digit_type                       pending[$];
      int                              errors;
      // private copy of the converter state
      logic [rdc_pkg::VALUE_BITS-1:0]  quotient;
      logic [rdc_pkg::RADIX_W-1:0]     held_radix;
      logic [rdc_pkg::INDEX_W-1:0]     position;

      function new();
         errors     = 0;
         quotient   = '0;
         held_radix = '0;
         position   = '0;
      endfunction

      function logic [rdc_pkg::CHAR_W-1:0] ascii_digit(
         input logic [rdc_pkg::RADIX_W-1:0] d);
         if (d < 10)
            return CHAR_ZERO + rdc_pkg::CHAR_W'(d);
         return CHAR_LETTER + rdc_pkg::CHAR_W'(d) - rdc_pkg::CHAR_W'(10);
      endfunction

      function void note_request(input logic [rdc_pkg::VALUE_BITS-1:0] value,
                                 input logic [rdc_pkg::RADIX_W-1:0] radix);
         digit_type                   e;
         logic [rdc_pkg::RADIX_W-1:0] d;
         int                          n;
         held_radix = radix;
         if (radix < rdc_pkg::RADIX_MIN || radix > rdc_pkg::RADIX_MAX) begin
            e.ch   = rdc_pkg::ERROR_CHAR;
            e.idx  = '0;
            e.last = 1'b1;
            e.bad  = 1'b1;
            pending.push_back(e);
            quotient = '0;
            position = '0;
            return;
         end
         quotient = value;
         n = 0;
         do begin
            d        = rdc_pkg::RADIX_W'(quotient % radix);
            quotient = quotient / radix;
            e.ch     = ascii_digit(d);
            e.idx    = rdc_pkg::INDEX_W'(n);
            e.last   = (quotient == 0) || (n == 31);
            e.bad    = 1'b0;
            pending.push_back(e);
            position = rdc_pkg::INDEX_W'(n);
            n++;
         end while (!e.last);
         quotient = '0;
      endfunction

      task report_mismatch(input string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_digit(input logic [rdc_pkg::CHAR_W-1:0] ch,
                       input logic [rdc_pkg::INDEX_W-1:0] idx,
                       input logic last, input logic bad);
         digit_type e;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected item ch=%h idx=%0d last=%b bad=%b",
                                      ch, idx, last, bad));
            return;
         end
         e = pending.pop_front();
         if (ch !== e.ch)
            report_mismatch($sformatf("digit_char %h, want %h (idx %0d)", ch, e.ch, e.idx));
         if (idx !== e.idx)
            report_mismatch($sformatf("digit_index %0d, want %0d", idx, e.idx));
         if (last !== e.last)
            report_mismatch($sformatf("last %b, want %b (idx %0d)", last, e.last, e.idx));
         if (bad !== e.bad)
            report_mismatch($sformatf("bad_radix %b, want %b (idx %0d)", bad, e.bad, e.idx));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   no_idle;   // set during the quiet stretch: neither side stalls

   rdc_req_if req_chan();
   rdc_rsp_if rsp_chan();

   digit_scoreboard book = new();

   radix_digit_converter uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs. Worst legitimate run is roughly a
   // sixth of this (310 items of at most 32 digits each, 20 ns clock).
   initial begin
      #50ms;
      $display("radix_digit_converter regression: fail");
      $finish;
   end

   // Result side backpressure: unless no_idle is set, ready drops roughly 16 times in 100,
   // decided fresh every cycle so stalls land on every phase of the output.
   always @(posedge clock) begin
      rsp_chan.ready <= no_idle || ($urandom_range(0, 99) >= 16);
   end

   // Every accepted result item is checked against the oldest expectation.
   // Sampling right after the edge sees pre-edge values, since every signal
   // involved only changes through nonblocking updates.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         book.check_digit(rsp_chan.digit_char, rsp_chan.digit_index,
                          rsp_chan.last, rsp_chan.bad_radix);
   end

   // Offer one request item and return at the edge where it is taken.
   // valid is only lowered when a gap follows, so a back-to-back item never
   // sees valid dropped and raised in the same step.
   task automatic send_item(input logic [rdc_pkg::VALUE_BITS-1:0] value,
                            input logic [rdc_pkg::RADIX_W-1:0] radix);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(0, 99) < 16)
         gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value <= value;
      req_chan.radix <= radix;
      do @(posedge clock); while (!req_chan.ready);
      book.note_request(value, radix);
   endtask

   // Mostly legal bases, with the edge bases favored and a few illegal ones.
   function automatic logic [rdc_pkg::RADIX_W-1:0] random_radix();
      case ($urandom_range(0, 24))
         0:       return rdc_pkg::RADIX_MIN;
         1:       return rdc_pkg::RADIX_MAX;
         2:       return 6'd10;
         3:       return 6'd16;
         4:       return rdc_pkg::RADIX_W'($urandom_range(0, 1));
         5:       return rdc_pkg::RADIX_W'($urandom_range(37, 63));
         default: return rdc_pkg::RADIX_W'($urandom_range(2, 36));
      endcase
   endfunction

   // Mix of full-range values, short conversions, values near the top, values
   // around powers of the base (where the digit count changes) and powers of two.
   function automatic logic [rdc_pkg::VALUE_BITS-1:0] random_value(
      input logic [rdc_pkg::RADIX_W-1:0] radix);
      logic [63:0] p;
      int          k;
      int          i;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return $urandom_range(0, 2000);
         6:          return 32'hFFFF_FFFF - $urandom_range(0, 255);
         7: begin
            p = 64'd1;
            k = $urandom_range(1, 31);
            if (radix >= rdc_pkg::RADIX_MIN)
               for (i = 0; i < k && p * radix <= 64'hFFFF_FFFF; i++)
                  p = p * radix;
            return p[31:0] + $urandom_range(0, 2) - 1;
         end
         default:    return 32'h1 << $urandom_range(0, 31);
      endcase
   endfunction

   initial begin
      int j;
      req_chan.valid <= 1'b0;
      req_chan.value <= '0;
      req_chan.radix <= '0;
      no_idle        <= 1'b0;
      reset          <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero in several bases, full-scale in base 2 (32 digits),
      // letters at the top of base 36, digit-count boundaries, bad bases.
      send_item(32'd0,          6'd10);
      send_item(32'd0,          rdc_pkg::RADIX_MIN);
      send_item(32'd0,          rdc_pkg::RADIX_MAX);
      send_item(32'hFFFF_FFFF,  rdc_pkg::RADIX_MIN);
      send_item(32'hFFFF_FFFF,  rdc_pkg::RADIX_MAX);
      send_item(32'hFFFF_FFFF,  6'd16);
      send_item(32'h8000_0000,  rdc_pkg::RADIX_MIN);
      send_item(32'd1,          rdc_pkg::RADIX_MIN);
      send_item(32'd35,         rdc_pkg::RADIX_MAX);       // single 'Z'
      send_item(32'd36,         rdc_pkg::RADIX_MAX);       // "10"
      send_item(32'd1295,       rdc_pkg::RADIX_MAX);       // "ZZ"
      send_item(32'd2176782335, rdc_pkg::RADIX_MAX);       // all Z, one below 36^6
      send_item(32'd2176782336, rdc_pkg::RADIX_MAX);       // 36^6
      send_item(32'd9,          6'd10);
      send_item(32'd10,         6'd10);
      send_item(32'd123456789,  6'd10);
      send_item(32'hDEAD_BEEF,  6'd32);
      send_item(32'd12345,      6'd0);            // bad base: zero
      send_item(32'd0,          6'd1);            // bad base: one
      send_item(32'h7777_7777,  6'd37);           // bad base just above range
      send_item(32'hFFFF_FFFF,  6'd63);           // bad base, all radix bits set
      send_item(32'd35,         6'd35);           // "10" in base 35
      send_item(32'd34,         6'd35);           // 'Y'

      // Random items; a stretch in the middle runs with no idling on either side
      for (j = 0; j < RANDOM_ITEMS; j++) begin
         logic [rdc_pkg::RADIX_W-1:0] r;
         if (j == 120)
            no_idle <= 1'b1;
         else if (j == 180)
            no_idle <= 1'b0;
         r = random_radix();
         send_item(random_value(r), r);
      end
      req_chan.valid <= 1'b0;

      // Drain, then give the block time to show any stray trailing items
      while (book.pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (book.errors == 0 && book.pending.size() == 0)
         $display("radix_digit_converter regression: pass");
      else
         $display("radix_digit_converter regression: fail");
      $finish;
   end

endmodule
